>>> rtl/core/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; every other file of the block imports this package.
package pps_pkg;

  // Default table depth; the top level takes its MAX_JOBS default from here.
  localparam int MAX_JOBS_DEF = 64;

  // Fixed field widths.
  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRI_W   = 8;
  localparam int TIME_W  = 20;
  localparam int SUM_W   = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  // Input word action codes.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  // Best-candidate record passed from cell to cell during a scan.
  typedef struct packed {
    logic               found;
    logic [PRI_W-1:0]   pri;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] rem;
  } probe_t;

  // Broadcast controls from the controller to the row of cells.
  typedef struct packed {
    logic               load;
    logic               dec;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   priority_val;
  } cell_ctrl_t;

endpackage

>>> rtl/core/pps_in_if.sv
// Input channel of the scheduler: valid/ready handshake with the job word.
// Depends on pps_pkg for field widths.
interface pps_in_if
  import pps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [ARR_W-1:0]   arrival_time;
  logic [BURST_W-1:0] burst_time;
  logic [PRI_W-1:0]   priority_req;

  modport source (output valid, action, arrival_time, burst_time, priority_req,
                  input ready);
  modport sink   (input valid, action, arrival_time, burst_time, priority_req,
                  output ready);
endinterface

>>> rtl/core/pps_out_if.sv
// Result channel of the scheduler: valid/ready handshake with the result word.
// Depends on pps_pkg for field widths.
interface pps_out_if
  import pps_pkg::*;
#(
  parameter int ID_W = $clog2(MAX_JOBS_DEF + 1)
) ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   running_id;
  logic [TIME_W-1:0] time_now;
  logic              new_segment;
  logic              job_completed;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;
  logic [SUM_W-1:0]  sum_turnaround;
  logic [SUM_W-1:0]  sum_waiting;
  logic              all_done;
  logic              table_full;

  modport source (output valid, running_id, time_now, new_segment, job_completed,
                  turnaround, waiting, sum_turnaround, sum_waiting, all_done,
                  table_full, input ready);
  modport sink   (input valid, running_id, time_now, new_segment, job_completed,
                  turnaround, waiting, sum_turnaround, sum_waiting, all_done,
                  table_full, output ready);
endinterface

>>> rtl/core/pps_cell.sv
// One job-table cell: holds one job entry and takes one step of the best-job scan.
// Depends on pps_pkg for the probe and control structs.
module pps_cell
  import pps_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF,
  parameter int INDEX    = 0
) (
  input  logic                                clk,
  input  cell_ctrl_t                          ctrl,
  input  logic [$clog2(MAX_JOBS)-1:0]         load_idx,
  input  logic [$clog2(MAX_JOBS)-1:0]         dec_idx,
  input  logic [$clog2(MAX_JOBS + 1)-1:0]     job_count,
  input  logic [TIME_W-1:0]                   time_now,
  input  probe_t                              probe_in,
  input  logic [$clog2(MAX_JOBS)-1:0]         probe_idx_in,
  output probe_t                              probe_out,
  output logic [$clog2(MAX_JOBS)-1:0]         probe_idx_out
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_NUM = CNT_W'(INDEX);

  logic [ARR_W-1:0]   arrival;
  logic [BURST_W-1:0] burst;
  logic [PRI_W-1:0]   priority_val;
  logic [BURST_W-1:0] remaining;

  logic eligible;
  logic take;

  // Entry storage: written on load, remaining time counted down when this job runs.
  always_ff @(posedge clk) begin
    if (ctrl.load && load_idx == MY_IDX) begin
      arrival      <= ctrl.arrival;
      burst        <= ctrl.burst;
      priority_val <= ctrl.priority_val;
      remaining    <= ctrl.burst;
    end else if (ctrl.dec && dec_idx == MY_IDX) begin
      remaining <= remaining - BURST_W'(1);
    end
  end

  // A job competes once it is in the table, has arrived and still has work.
  // Ties on priority go to the earlier arrival, then to the lower id already in the probe.
  always_comb begin
    eligible = (MY_NUM < job_count) && ({{(TIME_W - ARR_W){1'b0}}, arrival} <= time_now)
               && (remaining != '0);
    take = eligible && (!probe_in.found || priority_val < probe_in.pri ||
                        (priority_val == probe_in.pri && arrival < probe_in.arr));
  end

  // Hand the best candidate so far to the next cell.
  always_ff @(posedge clk) begin
    if (take) begin
      probe_out.found <= 1'b1;
      probe_out.pri   <= priority_val;
      probe_out.arr   <= arrival;
      probe_out.burst <= burst;
      probe_out.rem   <= remaining;
      probe_idx_out   <= MY_IDX;
    end else begin
      probe_out     <= probe_in;
      probe_idx_out <= probe_idx_in;
    end
  end

endmodule

>>> rtl/core/pps_ctrl.sv
// Scheduler controller: handshakes, time, work and sum bookkeeping, scan sequencing.
// Depends on pps_pkg and the pps_in_if / pps_out_if channel interfaces.
module pps_ctrl
  import pps_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  pps_in_if.sink                          job_in,
  pps_out_if.source                       job_out,
  output cell_ctrl_t                      ctrl,
  output logic [$clog2(MAX_JOBS)-1:0]     load_idx,
  output logic [$clog2(MAX_JOBS)-1:0]     dec_idx,
  output logic [$clog2(MAX_JOBS + 1)-1:0] job_count,
  output logic [TIME_W-1:0]               time_counter,
  input  probe_t                          probe_last,
  input  logic [$clog2(MAX_JOBS)-1:0]     probe_idx_last
);

  localparam int IDX_W  = $clog2(MAX_JOBS);
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int ID_W   = CNT_W;
  localparam int WORK_W = BURST_W + $clog2(MAX_JOBS);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_UPDATE = 6'b000100,
    ST_WAIT   = 6'b001000,
    ST_ACCUM  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t              state;
  logic [IDX_W-1:0]    scan_cnt;
  logic [WORK_W-1:0]   work_left;
  logic [ID_W-1:0]     last_run_id;
  logic [SUM_W-1:0]    turnaround_total;
  logic [SUM_W-1:0]    waiting_total;
  logic [ID_W-1:0]     run_id;
  logic                new_seg;
  logic                completed;
  logic [TIME_W-1:0]   tat;
  logic [TIME_W-1:0]   wt;
  logic [BURST_W-1:0]  win_burst;
  logic                full_flag;

  logic                in_fire;
  logic                is_full;
  logic                out_free;
  logic [TIME_W-1:0]   time_inc;
  logic [ID_W-1:0]     win_id;
  logic [SUM_W:0]      tat_sum;
  logic [SUM_W:0]      wt_sum;

  assign job_in.ready = (state == ST_IDLE);
  assign in_fire      = job_in.valid && job_in.ready;
  assign is_full      = (job_count == CNT_W'(MAX_JOBS));
  assign out_free     = !job_out.valid || job_out.ready;
  assign load_idx     = job_count[IDX_W-1:0];
  assign dec_idx      = probe_idx_last;

  // Saturating time step, winner id and widened sums.
  always_comb begin
    time_inc = (time_counter == TIME_MAX) ? time_counter : time_counter + TIME_W'(1);
    win_id   = ID_W'(probe_idx_last) + ID_W'(1);
    tat_sum  = {1'b0, turnaround_total} + {{(SUM_W + 1 - TIME_W){1'b0}}, tat};
    wt_sum   = {1'b0, waiting_total} + {{(SUM_W + 1 - TIME_W){1'b0}}, wt};
  end

  // Broadcast to the cells: load on an accepted load word while the table has room, countdown on the winner.
  always_comb begin
    ctrl.load         = in_fire && (job_in.action == ACT_LOAD) && !is_full;
    ctrl.dec          = (state == ST_UPDATE) && probe_last.found;
    ctrl.arrival      = job_in.arrival_time;
    ctrl.burst        = job_in.burst_time;
    ctrl.priority_val = job_in.priority_req;
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      scan_cnt         <= '0;
      job_count        <= '0;
      time_counter     <= '0;
      work_left        <= '0;
      last_run_id      <= '0;
      turnaround_total <= '0;
      waiting_total    <= '0;
      run_id           <= '0;
      new_seg          <= 1'b0;
      completed        <= 1'b0;
      tat              <= '0;
      wt               <= '0;
      win_burst        <= '0;
      full_flag        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            run_id    <= '0;
            new_seg   <= 1'b0;
            completed <= 1'b0;
            tat       <= '0;
            wt        <= '0;
            full_flag <= 1'b0;
            state     <= ST_EMIT;
            case (job_in.action)
              ACT_LOAD: begin
                if (is_full) begin
                  full_flag <= 1'b1;
                end else begin
                  job_count <= job_count + CNT_W'(1);
                  work_left <= work_left + WORK_W'(job_in.burst_time);
                end
              end
              ACT_TICK: begin
                if (work_left != '0) begin
                  scan_cnt <= '0;
                  state    <= ST_SCAN;
                end
              end
              ACT_CLEAR: begin
                job_count        <= '0;
                time_counter     <= '0;
                work_left        <= '0;
                last_run_id      <= '0;
                turnaround_total <= '0;
                waiting_total    <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        // The probe walks one cell per cycle along the row.
        ST_SCAN: begin
          scan_cnt <= scan_cnt + IDX_W'(1);
          if (scan_cnt == IDX_W'(MAX_JOBS - 1)) begin
            state <= ST_UPDATE;
          end
        end
        // Advance time and charge one unit to the winner, if any.
        ST_UPDATE: begin
          time_counter <= time_inc;
          win_burst    <= probe_last.burst;
          if (probe_last.found) begin
            work_left   <= work_left - WORK_W'(1);
            run_id      <= win_id;
            new_seg     <= (last_run_id != win_id);
            last_run_id <= win_id;
            if (probe_last.rem == BURST_W'(1)) begin
              completed <= 1'b1;
              if (time_inc > {{(TIME_W - ARR_W){1'b0}}, probe_last.arr}) begin
                tat <= time_inc - {{(TIME_W - ARR_W){1'b0}}, probe_last.arr};
              end
            end
          end
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (completed && tat > {{(TIME_W - BURST_W){1'b0}}, win_burst}) begin
            wt <= tat - {{(TIME_W - BURST_W){1'b0}}, win_burst};
          end
          state <= ST_ACCUM;
        end
        // Saturating running sums.
        ST_ACCUM: begin
          if (completed) begin
            turnaround_total <= tat_sum[SUM_W] ? SUM_MAX : tat_sum[SUM_W-1:0];
            waiting_total    <= wt_sum[SUM_W] ? SUM_MAX : wt_sum[SUM_W-1:0];
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: holds a word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_out.valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      job_out.valid <= 1'b1;
    end else if (job_out.ready) begin
      job_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      job_out.running_id     <= run_id;
      job_out.time_now       <= time_counter;
      job_out.new_segment    <= new_seg;
      job_out.job_completed  <= completed;
      job_out.turnaround     <= tat;
      job_out.waiting        <= wt;
      job_out.sum_turnaround <= turnaround_total;
      job_out.sum_waiting    <= waiting_total;
      job_out.all_done       <= (work_left == '0);
      job_out.table_full     <= full_flag;
    end
  end

endmodule

>>> rtl/core/preemptive_priority_scheduler_top.sv
// Preemptive priority scheduler: a row of MAX_JOBS job cells and a controller.
// A result word is registered in the emit state once a load, clear or no-work tick is accepted;
// after a working tick the probe first walks the row, then the update, wait and accum states run.
// One word in flight: the next is taken only after emit, which a stalled result sink can hold.
// Reset clears time, counts and sums; job entries are undefined until loaded.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_cell and pps_ctrl.
module preemptive_priority_scheduler_top
  import pps_pkg::*;
#(
  parameter int MAX_JOBS = MAX_JOBS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pps_in_if.sink    job_in,
  pps_out_if.source job_out
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  cell_ctrl_t          ctrl;
  logic [IDX_W-1:0]    load_idx;
  logic [IDX_W-1:0]    dec_idx;
  logic [CNT_W-1:0]    job_count;
  logic [TIME_W-1:0]   time_counter;
  probe_t              probe     [MAX_JOBS + 1];
  logic [IDX_W-1:0]    probe_idx [MAX_JOBS + 1];

  // The probe enters the row empty.
  assign probe[0]     = '0;
  assign probe_idx[0] = '0;

  pps_ctrl #(
    .MAX_JOBS(MAX_JOBS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .job_in        (job_in),
    .job_out       (job_out),
    .ctrl          (ctrl),
    .load_idx      (load_idx),
    .dec_idx       (dec_idx),
    .job_count     (job_count),
    .time_counter  (time_counter),
    .probe_last    (probe[MAX_JOBS]),
    .probe_idx_last(probe_idx[MAX_JOBS])
  );

  // Row of job cells, each passing its best candidate to the next.
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    pps_cell #(
      .MAX_JOBS(MAX_JOBS),
      .INDEX   (i)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .load_idx     (load_idx),
      .dec_idx      (dec_idx),
      .job_count    (job_count),
      .time_now     (time_counter),
      .probe_in     (probe[i]),
      .probe_idx_in (probe_idx[i]),
      .probe_out    (probe[i + 1]),
      .probe_idx_out(probe_idx[i + 1])
    );
  end

endmodule

>>> tb/pps_schedule_checker.sv
// Checker for the preemptive priority scheduler: watches both channels,
// predicts every result word and compares it field by field.
// Depends on pps_pkg, pps_in_if and pps_out_if.
module pps_schedule_checker
  import pps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pps_in_if    job_in,
  pps_out_if   job_out,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int JOB_SLOTS = MAX_JOBS_DEF;
  localparam int ID_BITS   = 7;

  typedef enum logic [1:0] {
    JOB_WAITING = 2'd0,
    JOB_ARRIVED = 2'd1,
    JOB_DONE    = 2'd2
  } job_state_t;

  typedef struct packed {
    logic [ID_BITS-1:0] running_id;
    logic [TIME_W-1:0]  time_now;
    logic               new_segment;
    logic               job_completed;
    logic [TIME_W-1:0]  turnaround;
    logic [TIME_W-1:0]  waiting;
    logic [SUM_W-1:0]   sum_turnaround;
    logic [SUM_W-1:0]   sum_waiting;
    logic               all_done;
    logic               table_full;
  } sched_report_t;

  // Private copy of the job table and the scheduler counters.
  logic [ARR_W-1:0]   arrive_at [JOB_SLOTS];
  logic [BURST_W-1:0] service   [JOB_SLOTS];
  logic [PRI_W-1:0]   rank      [JOB_SLOTS];
  logic [BURST_W-1:0] units_left[JOB_SLOTS];
  job_state_t         job_state [JOB_SLOTS];
  int                 jobs_held;
  logic [TIME_W-1:0]  clock_now;
  logic [21:0]        work_units;
  logic [ID_BITS-1:0] prev_id;
  logic [SUM_W-1:0]   tat_total;
  logic [SUM_W-1:0]   wait_total;

  sched_report_t awaited_reports[$];

  function automatic void wipe_schedule();
    jobs_held  = 0;
    clock_now  = '0;
    work_units = '0;
    prev_id    = '0;
    tat_total  = '0;
    wait_total = '0;
  endfunction

  function automatic logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    logic [SUM_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
  endfunction

  // Apply one accepted word to the private state and build its report.
  function automatic sched_report_t schedule_step(logic [1:0] act, logic [ARR_W-1:0] arr,
                                                  logic [BURST_W-1:0] burst,
                                                  logic [PRI_W-1:0] pri);
    sched_report_t     rep;
    bit                found;
    int                pick;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;
    rep   = '0;
    found = 1'b0;
    pick  = 0;
    case (act)
      ACT_LOAD: begin
        if (jobs_held >= JOB_SLOTS) begin
          rep.table_full = 1'b1;
        end else begin
          arrive_at[jobs_held]  = arr;
          service[jobs_held]    = burst;
          rank[jobs_held]       = pri;
          units_left[jobs_held] = burst;
          job_state[jobs_held]  = JOB_WAITING;
          jobs_held++;
          work_units += 22'(burst);
        end
      end
      ACT_TICK: begin
        if (work_units != '0) begin
          // Mark arrivals, then pick the best runnable job.
          for (int i = 0; i < jobs_held; i++) begin
            if (job_state[i] == JOB_WAITING && TIME_W'(arrive_at[i]) <= clock_now)
              job_state[i] = JOB_ARRIVED;
          end
          for (int i = 0; i < jobs_held; i++) begin
            if (job_state[i] == JOB_ARRIVED && units_left[i] != '0) begin
              if (!found || rank[i] < rank[pick] ||
                  (rank[i] == rank[pick] && arrive_at[i] < arrive_at[pick])) begin
                pick  = i;
                found = 1'b1;
              end
            end
          end
          if (clock_now != TIME_MAX) clock_now++;
          if (found) begin
            units_left[pick]--;
            work_units--;
            rep.running_id  = ID_BITS'(pick + 1);
            rep.new_segment = (prev_id != ID_BITS'(pick + 1));
            prev_id         = ID_BITS'(pick + 1);
            if (units_left[pick] == '0) begin
              job_state[pick] = JOB_DONE;
              tat = (clock_now > TIME_W'(arrive_at[pick])) ?
                    clock_now - TIME_W'(arrive_at[pick]) : '0;
              wt  = (tat > TIME_W'(service[pick])) ? tat - TIME_W'(service[pick]) : '0;
              tat_total  = add_clamped(tat_total, SUM_W'(tat));
              wait_total = add_clamped(wait_total, SUM_W'(wt));
              rep.job_completed = 1'b1;
              rep.turnaround    = tat;
              rep.waiting       = wt;
            end
          end
        end
      end
      ACT_CLEAR: wipe_schedule();
      default: ;
    endcase
    rep.time_now       = clock_now;
    rep.sum_turnaround = tat_total;
    rep.sum_waiting    = wait_total;
    rep.all_done       = (work_units == '0);
    return rep;
  endfunction

  task automatic check_field(input string label, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Predict on every accepted input word, compare on every accepted result word.
  always @(posedge clk) begin
    sched_report_t want;
    if (rst) begin
      wipe_schedule();
      awaited_reports.delete();
    end else begin
      if (job_in.valid && job_in.ready)
        awaited_reports.push_back(schedule_step(job_in.action, job_in.arrival_time,
                                                job_in.burst_time, job_in.priority_req));
      if (job_out.valid && job_out.ready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual id %0d time_now %0d",
                   $time, job_out.running_id, job_out.time_now);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          check_field("running_id", SUM_W'(want.running_id), SUM_W'(job_out.running_id));
          check_field("time_now", SUM_W'(want.time_now), SUM_W'(job_out.time_now));
          check_field("new_segment", SUM_W'(want.new_segment), SUM_W'(job_out.new_segment));
          check_field("job_completed", SUM_W'(want.job_completed),
                      SUM_W'(job_out.job_completed));
          check_field("turnaround", SUM_W'(want.turnaround), SUM_W'(job_out.turnaround));
          check_field("waiting", SUM_W'(want.waiting), SUM_W'(job_out.waiting));
          check_field("sum_turnaround", want.sum_turnaround, job_out.sum_turnaround);
          check_field("sum_waiting", want.sum_waiting, job_out.sum_waiting);
          check_field("all_done", SUM_W'(want.all_done), SUM_W'(job_out.all_done));
          check_field("table_full", SUM_W'(want.table_full), SUM_W'(job_out.table_full));
        end
      end
    end
    pending = awaited_reports.size();
  end

endmodule

>>> tb/preemptive_priority_scheduler_top_test.sv
// Top of the scheduler testbench: clock, reset, directed and random job words,
// random stalls on the result side, and the final verdict.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_schedule_checker and the block.
module preemptive_priority_scheduler_top_test;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1450;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   words_sent;
  bit   no_idle;

  pps_in_if  job_in ();
  pps_out_if job_out ();

  preemptive_priority_scheduler_top DUT (
    .clk     (clk),
    .rst     (rst),
    .job_in  (job_in),
    .job_out (job_out)
  );

  pps_schedule_checker sched_check (
    .clk        (clk),
    .rst        (rst),
    .job_in     (job_in),
    .job_out    (job_out),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 40));
  endfunction

  // Present one word from a falling edge and hold it until it is taken.
  task automatic send_word(input logic [1:0] act, input logic [ARR_W-1:0] arr,
                           input logic [BURST_W-1:0] burst, input logic [PRI_W-1:0] pri);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      job_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    job_in.valid        <= 1'b1;
    job_in.action       <= act;
    job_in.arrival_time <= arr;
    job_in.burst_time   <= burst;
    job_in.priority_req <= pri;
    @(posedge clk);
    while (!job_in.ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Clear, load a job set, then tick until the work must be gone.
  task automatic run_schedule(input int jobs, input int max_arr, input int max_burst,
                              input bit wide_pri);
    int                 ticks_left;
    int                 latest;
    logic [ARR_W-1:0]   a;
    logic [BURST_W-1:0] b;
    logic [PRI_W-1:0]   p;
    ticks_left = 0;
    latest     = 0;
    send_word(ACT_CLEAR, ARR_W'($urandom()), BURST_W'($urandom()), PRI_W'($urandom()));
    for (int j = 0; j < jobs; j++) begin
      a = ARR_W'($urandom_range(0, max_arr));
      b = ($urandom_range(0, 9) == 0) ? '0 : BURST_W'($urandom_range(1, max_burst));
      p = wide_pri ? PRI_W'($urandom_range(0, 255)) : PRI_W'($urandom_range(0, 3));
      send_word(ACT_LOAD, a, b, p);
      ticks_left += int'(b);
      if (int'(a) > latest) latest = int'(a);
    end
    ticks_left += latest + int'($urandom_range(0, 3));
    while (ticks_left > 0) begin
      if ($urandom_range(0, 15) == 0) begin
        // A job loaded while the schedule runs, possibly preempting.
        a = ARR_W'($urandom_range(0, max_arr));
        b = BURST_W'($urandom_range(1, max_burst));
        p = wide_pri ? PRI_W'($urandom_range(0, 255)) : PRI_W'($urandom_range(0, 3));
        send_word(ACT_LOAD, a, b, p);
        // Its work, plus any wait for an arrival later than all before it.
        ticks_left += int'(b);
        if (int'(a) > latest) begin
          ticks_left += int'(a) - latest;
          latest = int'(a);
        end
      end else begin
        send_word(ACT_TICK, ARR_W'($urandom()), BURST_W'($urandom()), PRI_W'($urandom()));
        ticks_left--;
      end
    end
  endtask

  // Result side: random stalls, with occasional long stretches of steady ready.
  initial begin
    int  r;
    int  span;
    logic lvl;
    job_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      r = int'($urandom_range(0, 19));
      if (r == 0) begin
        lvl  = 1'b1;
        span = int'($urandom_range(100, 400));
      end else if (r < 12) begin
        lvl  = 1'b1;
        span = int'($urandom_range(1, 8));
      end else begin
        lvl  = 1'b0;
        span = pick_gap();
        if (span == 0) span = 1;
      end
      job_out.ready <= lvl;
      if (span > 1) repeat (span - 1) @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int                 kind;
    int                 ticks_left;
    int                 loads;
    logic [BURST_W-1:0] b;
    job_in.valid        = 1'b0;
    job_in.action       = ACT_LOAD;
    job_in.arrival_time = '0;
    job_in.burst_time   = '0;
    job_in.priority_req = '0;
    words_sent          = 0;
    no_idle             = 1'b0;
    rst                 = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty tick, unknown action, zero burst, preemption,
    // priority ties broken by arrival and by id, idle ticks, extremes, clear.
    send_word(ACT_TICK, '0, '0, '0);
    send_word(ACT_UNUSED, '1, '1, '1);
    send_word(ACT_LOAD, 16'd0, 16'd0, 8'd0);
    send_word(ACT_LOAD, 16'd1, 16'd3, 8'd200);
    send_word(ACT_LOAD, 16'd2, 16'd1, 8'd0);
    send_word(ACT_LOAD, 16'd0, 16'd2, 8'd200);
    send_word(ACT_LOAD, 16'd1, 16'd1, 8'd200);
    send_word(ACT_LOAD, 16'd12, 16'd1, 8'd255);
    repeat (14) send_word(ACT_TICK, '0, '0, '0);
    send_word(ACT_LOAD, '1, '1, '1);
    send_word(ACT_TICK, '1, '1, '1);
    send_word(ACT_CLEAR, '1, '1, '1);
    send_word(ACT_TICK, '0, '0, '0);

    // Random part, built from episodes of different shapes.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      kind    = int'($urandom_range(0, 19));
      if (kind < 2) begin
        // Fill the table past its end; the last accepted job gets work.
        ticks_left = 8;
        loads      = MAX_JOBS_DEF + int'($urandom_range(1, 3));
        send_word(ACT_CLEAR, ARR_W'($urandom()), BURST_W'($urandom()), PRI_W'($urandom()));
        for (int j = 0; j < loads; j++) begin
          if (j >= MAX_JOBS_DEF) b = BURST_W'($urandom());
          else if (j == MAX_JOBS_DEF - 1) b = BURST_W'($urandom_range(1, 2));
          else b = ($urandom_range(0, 15) == 0) ? BURST_W'(1) : '0;
          if (j < MAX_JOBS_DEF) ticks_left += int'(b);
          send_word(ACT_LOAD, ARR_W'($urandom_range(0, 3)), b, PRI_W'($urandom()));
        end
        repeat (ticks_left)
          send_word(ACT_TICK, ARR_W'($urandom()), BURST_W'($urandom()), PRI_W'($urandom()));
      end else if (kind < 5) begin
        // Raw noise over every action and full-range fields.
        repeat ($urandom_range(1, 6))
          send_word(2'($urandom_range(0, 3)), ARR_W'($urandom()), BURST_W'($urandom()),
                    PRI_W'($urandom()));
      end else if (kind < 8) begin
        run_schedule(int'($urandom_range(6, 16)), 30, 12, 1'b1);
      end else begin
        run_schedule(int'($urandom_range(1, 8)), 12, 6, ($urandom_range(0, 3) == 0));
      end
    end
    job_in.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (MAX_JOBS_DEF + 12) @(negedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/pps_pkg.sv
rtl/core/pps_in_if.sv
rtl/core/pps_out_if.sv
rtl/core/pps_cell.sv
rtl/core/pps_ctrl.sv
rtl/core/preemptive_priority_scheduler_top.sv
tb/pps_schedule_checker.sv
tb/preemptive_priority_scheduler_top_test.sv
